// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: prop is any property expression.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication: when cond holds, conseq holds in the cycle after.
`define ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/wc3_pkg.sv =====
// ----------------------------------------------------------------------------
// wc3_pkg
// Shared widths, register indexes and item types of the 3x3 window filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wc3_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int COEF_BITS  = 8;
  localparam int KSIZE      = 3;
  localparam int TAPS       = KSIZE * KSIZE;
  localparam int DIM_W      = 11;
  localparam int KROW_W     = KSIZE * COEF_BITS;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int OUT_W      = 20;
  localparam int PROD_W     = COEF_BITS + PIXEL_BITS + 1;
  localparam int ROW_W      = PROD_W + 2;
  localparam int SUM_W      = PROD_W + 4;
  localparam int MIN_DIM    = 3;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } cfg_reg_t;

  // Row 0 is the top kernel row; left coefficient in the low byte.
  typedef logic [KSIZE-1:0][KROW_W-1:0] kernel_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] filtered_value;
    logic                    row_end;
    logic                    frame_end;
  } out_item_t;

  // Pixel plus position flags resolved by the counters.
  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel;
    logic                  produce;
    logic                  row_end;
    logic                  frame_end;
  } pos_t;

  // Nine registered products, index row*KSIZE + column.
  typedef struct packed {
    logic [TAPS-1:0][PROD_W-1:0] prod;
    logic                        row_end;
    logic                        frame_end;
  } prod_item_t;

endpackage

// ===== rtl/wc3_ram.sv =====
// ----------------------------------------------------------------------------
// wc3_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read during write to the same address returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/wc3_window.sv =====
// ----------------------------------------------------------------------------
// wc3_window
// Line-store read/modify/write, 3x3 window and the nine products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wc3_window #(
  parameter int MAX_WIDTH = 1024,
  localparam int AW       = $clog2(MAX_WIDTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s_valid,
  output logic                s_ready,
  input  wc3_pkg::pos_t       s_item,
  input  logic [AW-1:0]       s_addr,
  input  wc3_pkg::kernel_t    kernel,
  output logic                p_valid,
  input  logic                p_ready,
  output wc3_pkg::prod_item_t p_item
);

  import wc3_pkg::*;

  localparam int LW = 2 * PIXEL_BITS;

  logic                  s1_v_r;
  pos_t                  s1_r;
  logic [AW-1:0]         s1_addr_r;
  logic                  fwd_r;
  logic [LW-1:0]         fwd_data_r;
  logic [LW-1:0]         ram_q;
  logic [LW-1:0]         rd_line;
  logic [LW-1:0]         wr_line;
  logic [PIXEL_BITS-1:0] win_r   [KSIZE][KSIZE];
  logic [PIXEL_BITS-1:0] win_nxt [KSIZE][KSIZE];
  logic                  s1_go;
  logic                  s_acc;
  logic                  prod_load;
  logic                  prod_v_r;
  prod_item_t            prod_r;
  prod_item_t            prod_nxt;

  function automatic logic [PROD_W-1:0] mul_px(input logic [COEF_BITS-1:0]  c,
                                               input logic [PIXEL_BITS-1:0] p);
    logic signed [PROD_W-1:0] cs;
    logic signed [PROD_W-1:0] ps;
    cs = $signed({{(PROD_W-COEF_BITS){c[COEF_BITS-1]}}, c});
    ps = $signed({{(PROD_W-PIXEL_BITS){1'b0}}, p});
    return cs * ps;
  endfunction

  // Non-producing items never wait on the product register.
  assign s1_go     = s1_v_r && (!s1_r.produce || !prod_v_r || p_ready);
  assign s_ready   = !s1_v_r || s1_go;
  assign s_acc     = s_valid && s_ready;
  assign prod_load = s1_go && s1_r.produce;

  // Line word is {older, newer}; a same-column write in the read cycle is forwarded.
  assign rd_line = fwd_r ? fwd_data_r : ram_q;
  assign wr_line = {rd_line[PIXEL_BITS-1:0], s1_r.pixel};

  wc3_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_go),
    .waddr (s1_addr_r),
    .wdata (wr_line),
    .re    (s_acc),
    .raddr (s_addr),
    .rdata (ram_q)
  );

  always_comb begin
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE - 1; j++) begin
        win_nxt[i][j] = win_r[i][j+1];
      end
    end
    win_nxt[0][KSIZE-1] = rd_line[LW-1:PIXEL_BITS];
    win_nxt[1][KSIZE-1] = rd_line[PIXEL_BITS-1:0];
    win_nxt[2][KSIZE-1] = s1_r.pixel;
  end

  always_comb begin
    prod_nxt.row_end   = s1_r.row_end;
    prod_nxt.frame_end = s1_r.frame_end;
    for (int i = 0; i < KSIZE; i++) begin
      for (int j = 0; j < KSIZE; j++) begin
        prod_nxt.prod[i*KSIZE+j] = mul_px(kernel[i][j*COEF_BITS +: COEF_BITS],
                                          win_nxt[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      if (s_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (prod_load) begin
        prod_v_r <= 1'b1;
      end else if (p_ready) begin
        prod_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_r       <= s_item;
      s1_addr_r  <= s_addr;
      fwd_r      <= s1_go && (s1_addr_r == s_addr);
      fwd_data_r <= wr_line;
    end
    if (s1_go) begin
      win_r <= win_nxt;
    end
    if (prod_load) begin
      prod_r <= prod_nxt;
    end
  end

  assign p_valid = prod_v_r;
  assign p_item  = prod_r;

  `ASSERT_NEXT(a_s1_hold, s1_v_r && !s1_go, s1_v_r && $stable(s1_addr_r) && $stable(fwd_r), "line stage lost its item while stalled")
  `ASSERT_NEXT(a_prod_hold, prod_v_r && !p_ready, prod_v_r && $stable(prod_r), "product register overwritten while stalled")

endmodule

// ===== rtl/wc3_sum.sv =====
// ----------------------------------------------------------------------------
// wc3_sum
// Two-level adder tree over the nine products, with the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wc3_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                p_valid,
  output logic                p_ready,
  input  wc3_pkg::prod_item_t p_item,
  output logic                out_valid,
  input  logic                out_ready,
  output wc3_pkg::out_item_t  out_item
);

  import wc3_pkg::*;

  logic                    rs_v_r;
  logic signed [ROW_W-1:0] rs_r   [KSIZE];
  logic signed [ROW_W-1:0] rs_nxt [KSIZE];
  logic                    rs_row_end_r;
  logic                    rs_frame_end_r;
  logic signed [SUM_W-1:0] total;
  logic                    rs_go;
  logic                    p_acc;
  logic                    out_valid_r;
  out_item_t               out_r;

  assign rs_go   = rs_v_r && (!out_valid_r || out_ready);
  assign p_ready = !rs_v_r || rs_go;
  assign p_acc   = p_valid && p_ready;

  always_comb begin
    for (int i = 0; i < KSIZE; i++) begin
      rs_nxt[i] = ROW_W'($signed(p_item.prod[i*KSIZE]))
                + ROW_W'($signed(p_item.prod[i*KSIZE+1]))
                + ROW_W'($signed(p_item.prod[i*KSIZE+2]));
    end
  end

  assign total = SUM_W'(rs_r[0]) + SUM_W'(rs_r[1]) + SUM_W'(rs_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rs_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p_acc) begin
        rs_v_r <= 1'b1;
      end else if (rs_go) begin
        rs_v_r <= 1'b0;
      end
      if (rs_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_acc) begin
      rs_r           <= rs_nxt;
      rs_row_end_r   <= p_item.row_end;
      rs_frame_end_r <= p_item.frame_end;
    end
    if (rs_go) begin
      out_r.filtered_value <= total[OUT_W-1:0];
      out_r.row_end        <= rs_row_end_r;
      out_r.frame_end      <= rs_frame_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `ASSERT_NEXT(a_rs_hold, rs_v_r && !rs_go, rs_v_r && $stable(rs_r[0]) && $stable(rs_r[2]), "row-sum stage changed while stalled")

endmodule

// ===== rtl/window_convolution_3x3.sv =====
// ----------------------------------------------------------------------------
// window_convolution_3x3
// 3x3 valid-only convolution over a raster pixel stream, one pixel per clock while out_ready holds.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake             | item
//   --------+-----------+-----------------------+-------------------------------
//   in_     | input     | in_valid / in_ready   | pixel, frame_start
//   out_    | output    | out_valid / out_ready | filtered_value, row_end, frame_end
//   cfg_    | input     | cfg_wr_en only        | cfg_index, cfg_wdata
//
// One pixel per clock sustained while out_ready holds; a result passes the line stage,
// products, row sums and output register after its pixel is taken.
// The line RAM (MAX_WIDTH x 16) is read at accept and written back as the item
// leaves the line stage; a same-column write in the read cycle is forwarded.
// Synchronous active-low reset clears counters, valids and registers only.
// Stalls back up stage by stage; in_ready drops only when the line stage is stuck.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module window_convolution_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel stream
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wc3_pkg::in_item_t                 in_data,
  // filtered results
  output logic                              out_valid,
  input  logic                              out_ready,
  output wc3_pkg::out_item_t                out_data,
  // register writes
  input  logic                              cfg_wr_en,
  input  logic [wc3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wc3_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import wc3_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int CNT_W  = (AW > RW) ? AW : RW;
  localparam int CMP_W  = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;

  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  kernel_t           kernel_r;

  logic [AW-1:0]     col_r;
  logic [RW-1:0]     row_r;
  logic [AW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [AW-1:0]     col_nxt;
  logic [RW-1:0]     row_nxt;
  logic [CMP_W-1:0]  w_eff;
  logic [CMP_W-1:0]  h_eff;
  logic              last_col;
  logic              last_row;
  logic              in_acc;
  pos_t              pos;

  // Out-of-range geometry is pinned into MIN_DIM..hi.
  function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [CMP_W-1:0] hi);
    logic [CMP_W-1:0] ve;
    ve = CMP_W'(v);
    if (ve < CMP_W'(MIN_DIM)) begin
      return CMP_W'(MIN_DIM);
    end else if (ve > hi) begin
      return hi;
    end
    return ve;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_RESET;
      height_r <= DIM_RESET;
      kernel_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r     <= cfg_wdata[DIM_W-1:0];
        REG_HEIGHT: height_r    <= cfg_wdata[DIM_W-1:0];
        REG_KTOP:   kernel_r[0] <= cfg_wdata[KROW_W-1:0];
        REG_KMID:   kernel_r[1] <= cfg_wdata[KROW_W-1:0];
        REG_KBOT:   kernel_r[2] <= cfg_wdata[KROW_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Raster position of the incoming pixel
  // --------------------------------------------------------------------------
  assign w_eff  = clamp_dim(width_r,  CMP_W'(MAX_WIDTH));
  assign h_eff  = clamp_dim(height_r, CMP_W'(MAX_HEIGHT));
  assign in_acc = in_valid && in_ready;

  assign cur_col  = in_data.frame_start ? '0 : col_r;
  assign cur_row  = in_data.frame_start ? '0 : row_r;
  // At-or-beyond compares so a shrunk geometry still wraps cleanly.
  assign last_col = (CMP_W'(cur_col) + CMP_W'(1)) >= w_eff;
  assign last_row = (CMP_W'(cur_row) + CMP_W'(1)) >= h_eff;

  always_comb begin
    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : cur_row + RW'(1);
    end else begin
      col_nxt = cur_col + AW'(1);
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Interior positions only: the window needs two rows and two columns behind.
  assign pos.pixel     = in_data.pixel;
  assign pos.produce   = (CMP_W'(cur_row) >= CMP_W'(KSIZE - 1)) &&
                         (CMP_W'(cur_col) >= CMP_W'(KSIZE - 1));
  assign pos.row_end   = last_col;
  assign pos.frame_end = last_col && last_row;

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic       p_valid;
  logic       p_ready;
  prod_item_t p_item;

  wc3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_valid),
    .s_ready (in_ready),
    .s_item  (pos),
    .s_addr  (cur_col),
    .kernel  (kernel_r),
    .p_valid (p_valid),
    .p_ready (p_ready),
    .p_item  (p_item)
  );

  wc3_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .p_valid   (p_valid),
    .p_ready   (p_ready),
    .p_item    (p_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  // Frame end is always also a row end.
  `ASSERT_CLK(a_frame_end_row_end, out_valid |-> (!out_data.frame_end || out_data.row_end), "frame end without row end")

endmodule
